// ===== rtl/core/smt_pkg.sv =====
package smt_pkg;

	// default sizing of the store
	localparam int DEF_CAPACITY    = 64;
	localparam int DEF_VALUE_WIDTH = 32;

	// fixed field widths of the stream beats
	localparam int MODE_W      = 2;
	localparam int VALUE_W     = 32;
	localparam int REPEAT_W    = 7;
	localparam int COUNT_OUT_W = 7;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	// operation codes carried in tuser
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd3;

	// result of one operation, handed from the sequencer to the output register
	typedef struct packed {
		logic                   found;
		logic [COUNT_OUT_W-1:0] occurrences;
		logic [COUNT_OUT_W-1:0] element_count;
		logic                   is_empty;
		logic                   overflow;
	} res_t;

endpackage

// ===== rtl/core/smt_ram.sv =====
module smt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/smt_seq.sv =====
module smt_seq #(
	parameter int CAPACITY = 64,
	parameter int KEY_W    = 32,
	parameter int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [smt_pkg::MODE_W-1:0]    mode,
	input  logic [KEY_W-1:0]              key,
	input  logic [smt_pkg::REPEAT_W-1:0]  reps,
	input  logic                          order_desc,
	input  logic                          res_ready,
	output logic                          idle,
	output logic                          res_valid,
	output smt_pkg::res_t                 res,
	output logic                          ram_we,
	output logic [ADDR_W-1:0]             ram_waddr,
	output logic [KEY_W-1:0]              ram_wdata,
	output logic [ADDR_W-1:0]             ram_raddr,
	input  logic [KEY_W-1:0]              ram_rdata
);
	import smt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = ((CNT_W > REPEAT_W) ? CNT_W : REPEAT_W) + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    pos_q;
	logic [CNT_W-1:0]    occ_q;
	logic                found_q;
	logic                ovf_q;
	logic [MODE_W-1:0]   mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [REPEAT_W-1:0] reps_q;
	logic                rv_s1;
	logic [ADDR_W-1:0]   ra_s1;

	logic             is_add;
	logic             is_remove;
	logic             eq_hit;
	logic             prec_hit;
	logic             stop_now;
	logic             end_now;
	logic             issue;
	logic [SUM_W-1:0] fit_sum;
	logic             fit_fail;
	logic [SUM_W-1:0] shift_dst;
	logic [CNT_W-1:0] ra_ext;
	logic [SUM_W-1:0] count_ext;
	logic [SUM_W-1:0] occ_ext;

	assign is_add    = (mode_q == MODE_ADD);
	assign is_remove = (mode_q == MODE_REMOVE);
	assign ra_ext    = CNT_W'(ra_s1);

	// compare the entry returned by the memory against the key
	assign eq_hit   = (ram_rdata == key_q);
	assign prec_hit = order_desc ? (ram_rdata >= key_q) : (ram_rdata <= key_q);

	// scan stops at the insert point, or at the first equal entry
	assign stop_now = (state_q == ST_SCAN) && rv_s1 &&
		((is_add && !prec_hit) || ((mode_q == MODE_REMOVE || mode_q == MODE_SEARCH) && eq_hit));
	assign end_now  = (state_q == ST_SCAN) && !rv_s1 && (ptr_q >= count_q);

	// one read issued per cycle while scanning or moving entries
	always_comb begin
		issue = 1'b0;
		case (state_q)
			ST_SCAN:  issue = !stop_now && (ptr_q < count_q);
			ST_SHIFT: issue = (rem_q != '0);
			default:  issue = 1'b0;
		endcase
	end

	// room check for an add
	assign fit_sum  = SUM_W'(count_q) + SUM_W'(reps);
	assign fit_fail = (fit_sum > SUM_W'(CAPACITY));

	// moved entry lands reps places up for add, one place down for remove
	assign shift_dst = is_add ? (SUM_W'(ra_s1) + SUM_W'(reps_q)) : (SUM_W'(ra_s1) - SUM_W'(1));

	// memory ports; reads run ahead of writes and never hit the written entry
	always_comb begin
		ram_raddr = ptr_q[ADDR_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = shift_dst[ADDR_W-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			ST_SHIFT: ram_we = rv_s1;
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q[ADDR_W-1:0];
				ram_wdata = key_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// read pipeline: address of the data that arrives next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ra_s1 <= ptr_q[ADDR_W-1:0];
		end
	end

	// operation latch
	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			key_q  <= key;
			reps_q <= reps;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
			occ_q   <= '0;
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ptr_q   <= '0;
						occ_q   <= '0;
						found_q <= 1'b0;
						ovf_q   <= (mode == MODE_ADD) && fit_fail;
						if (mode == MODE_ADD && fit_fail) begin
							state_q <= ST_DONE;
						end else if (mode == MODE_ADD && reps == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (rv_s1 && eq_hit && mode_q == MODE_COUNT) begin
						occ_q <= occ_q + CNT_W'(1);
					end
					if (stop_now || end_now) begin
						case (mode_q)
							MODE_ADD: begin
								pos_q   <= stop_now ? ra_ext : count_q;
								rem_q   <= count_q - (stop_now ? ra_ext : count_q);
								ptr_q   <= count_q - CNT_W'(1);
								state_q <= ST_SHIFT;
							end
							MODE_REMOVE: begin
								if (stop_now) begin
									found_q <= 1'b1;
									ptr_q   <= ra_ext + CNT_W'(1);
									rem_q   <= count_q - ra_ext - CNT_W'(1);
									state_q <= ST_SHIFT;
								end else begin
									state_q <= ST_DONE;
								end
							end
							MODE_SEARCH: begin
								found_q <= stop_now;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SHIFT: begin
					if (issue) begin
						ptr_q <= is_add ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));
						rem_q <= rem_q - CNT_W'(1);
					end else if (!rv_s1) begin
						if (is_remove) begin
							count_q <= count_q - CNT_W'(1);
							state_q <= ST_DONE;
						end else begin
							ptr_q   <= pos_q;
							rem_q   <= CNT_W'(reps_q);
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					ptr_q <= ptr_q + CNT_W'(1);
					rem_q <= rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						count_q <= count_q + CNT_W'(reps_q);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result fields, counts masked to the port width
	assign count_ext = SUM_W'(count_q);
	assign occ_ext   = SUM_W'(occ_q);

	assign idle                = (state_q == ST_IDLE);
	assign res_valid           = (state_q == ST_DONE);
	assign res.found           = found_q;
	assign res.occurrences     = occ_ext[COUNT_OUT_W-1:0];
	assign res.element_count   = count_ext[COUNT_OUT_W-1:0];
	assign res.is_empty        = (count_q == '0);
	assign res.overflow        = ovf_q;

endmodule

// ===== rtl/core/sorted_multiset_table.sv =====
// Sorted multiset table: keeps up to CAPACITY signed values in sorted order
// in one synchronous memory and runs one operation per input beat.
// Input channel s_axis: tuser carries the operation (add, remove one, search,
// count), tdata the value and, for add, the number of copies.
// Output channel m_axis: one result beat per input beat, in order, with the
// found flag, occurrence count, stored size, empty flag and overflow flag.
// cfg_we/cfg_wdata set ascending (0) or descending (1) order; write it only
// while no operation is in flight.
// An operation scans the stored entries one memory read per cycle and stops
// at the insert point, the entry to remove or the first match of a search
// (a count scans them all), moves the entries behind the insert or delete
// point one per cycle, then writes the new copies one per cycle. A refused
// or zero-copy add skips these steps. The single memory port pair sets this
// pace.
// One operation is in flight at a time; s_axis_tready drops after each
// accepted beat and returns once the result moves into the output register.
// When the receiver stalls, the output register holds one result, the next
// operation finishes and waits with its result, and s_axis_tready stays low.
// Reset empties the table and selects ascending order; memory contents are
// not cleared since only entries below the stored size are ever read.
module sorted_multiset_table #(
	parameter int CAPACITY    = smt_pkg::DEF_CAPACITY,
	parameter int VALUE_WIDTH = smt_pkg::DEF_VALUE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] value, [38:32] repeat_req, [39] zero
	input  logic [smt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] mode
	input  logic [smt_pkg::MODE_W-1:0]         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] found, [7:1] occurrences, [14:8] element_count, [15] is_empty,
	// [16] overflow, [23:17] zero
	output logic [smt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import smt_pkg::*;

	localparam int KEY_W  = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                order_q;
	logic                m_valid_q;
	res_t                res_q;
	logic                accept;
	logic [KEY_W-1:0]    key_raw;
	logic [KEY_W-1:0]    key;
	logic                seq_idle;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [KEY_W-1:0]    ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [KEY_W-1:0]    ram_rdata;

	// order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	// biased key: flipping the sign bit makes unsigned order match signed order
	assign key_raw = s_axis_tdata[KEY_W-1:0];
	assign key     = {~key_raw[KEY_W-1], key_raw[KEY_W-2:0]};

	assign s_axis_tready = seq_idle;
	assign accept        = s_axis_tvalid && s_axis_tready;

	smt_seq #(
		.CAPACITY (CAPACITY),
		.KEY_W    (KEY_W),
		.ADDR_W   (ADDR_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.mode       (s_axis_tuser),
		.key        (key),
		.reps       (s_axis_tdata[VALUE_W +: REPEAT_W]),
		.order_desc (order_q),
		.res_ready  (res_ready),
		.idle       (seq_idle),
		.res_valid  (res_valid),
		.res        (res),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	smt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register, refilled as soon as the held beat goes out
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.overflow, res_q.is_empty, res_q.element_count,
		res_q.occurrences, res_q.found};

`ifndef SYNTH
	// one operation at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input accepted while an operation was running");

	// no new operation while a result waits for the output register
	a_result_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_axis_tready)
		else $error("input ready while a result is pending");

	// memory is only written by a running operation
	a_quiet_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !s_axis_tready)
		else $error("memory written while idle");

	// a refused add reports neither a find nor an occurrence count
	a_overflow_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_q.overflow) |-> (!res_q.found && res_q.occurrences == '0))
		else $error("overflow result carries other flags");
`endif

endmodule

// ===== bench/sorted_multiset_table_test.sv =====
`timescale 1ns / 100ps

module sorted_multiset_table_test;

	import smt_pkg::*;

	localparam int CAP          = DEF_CAPACITY;
	localparam int CYCLE_LIMIT  = 1_200_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2 * CAP + 127 + 8;
	localparam int PRINT_LIMIT  = 40;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [MODE_W-1:0]          mode;
		logic signed [VALUE_W-1:0]  value;
		logic [REPEAT_W-1:0]        reps;
	} op_item_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic                    cfg_wdata = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [MODE_W-1:0]       s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;

	// operations waiting to be offered, and the results they should produce
	op_item_t pending_ops[$];
	res_t     expected_res[$];
	op_item_t offered_op;

	// shadow copy of the table and of the order register
	logic signed [VALUE_W-1:0] shadow_vals [0:CAP-1];
	int   table_size = 0;
	logic order_desc = 1'b0;

	// values reused within a phase so that removes, searches and counts hit
	logic signed [VALUE_W-1:0] pool_vals [0:7];

	int   queued_count = 0;
	int   accepted_count = 0;
	int   result_count = 0;
	int   mismatch_count = 0;
	int   refused_adds = 0;
	int   hit_count = 0;
	int   cycle_count = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   hold_left = 0;
	int   stall_ticket = 0;
	int   stall_served = 0;
	logic calm = 1'b0;

	sorted_multiset_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stored entry a stays ahead of value v under the current order
	function automatic logic stays_ahead(logic signed [VALUE_W-1:0] a,
			logic signed [VALUE_W-1:0] v);
		return order_desc ? (a >= v) : (a <= v);
	endfunction

	// run one operation on the shadow table and return its result
	function automatic res_t apply_op(op_item_t op);
		res_t r;
		int   pos;
		int   n;
		r = '0;
		n = int'(op.reps);
		case (op.mode)
			MODE_ADD: begin
				if (table_size + n > CAP) begin
					r.overflow = 1'b1;
					refused_adds++;
				end else if (n > 0) begin
					pos = 0;
					while (pos < table_size && stays_ahead(shadow_vals[pos], op.value))
						pos++;
					for (int i = table_size - 1; i >= pos; i--)
						shadow_vals[i + n] = shadow_vals[i];
					for (int k = 0; k < n; k++)
						shadow_vals[pos + k] = op.value;
					table_size += n;
				end
			end
			MODE_REMOVE: begin
				pos = -1;
				for (int i = 0; i < table_size; i++)
					if (pos < 0 && shadow_vals[i] == op.value)
						pos = i;
				if (pos >= 0) begin
					for (int j = pos; j + 1 < table_size; j++)
						shadow_vals[j] = shadow_vals[j + 1];
					table_size--;
					r.found = 1'b1;
					hit_count++;
				end
			end
			MODE_SEARCH: begin
				for (int i = 0; i < table_size; i++)
					if (shadow_vals[i] == op.value)
						r.found = 1'b1;
				if (r.found)
					hit_count++;
			end
			default: begin
				n = 0;
				for (int i = 0; i < table_size; i++)
					if (shadow_vals[i] == op.value)
						n++;
				r.occurrences = n[COUNT_OUT_W-1:0];
			end
		endcase
		r.element_count = table_size[COUNT_OUT_W-1:0];
		r.is_empty = (table_size == 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				result_count, what, got, want);
		mismatch_count++;
	endtask

	// input driver: holds a beat until taken, idles in bursts between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_res.push_back(apply_op(offered_op));
				accepted_count++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// beat still waiting, keep it as it is
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 5);
				s_axis_tvalid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				offered_op = pending_ops.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= offered_op.mode;
				s_axis_tdata <= {1'b0, offered_op.reps, offered_op.value};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, started on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			stall_served <= 0;
		end else if (stall_served != stall_ticket) begin
			hold_left <= HOLD_CYCLES;
			stall_served <= stall_ticket;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver ready with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(0, 5);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result monitor: each beat against the oldest expectation
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected result beat, tdata", int'(m_axis_tdata), 0);
			end else begin
				want = expected_res.pop_front();
				if (m_axis_tdata[0] !== want.found)
					report_mismatch("found", int'(m_axis_tdata[0]), int'(want.found));
				if (m_axis_tdata[7:1] !== want.occurrences)
					report_mismatch("occurrences", int'(m_axis_tdata[7:1]),
						int'(want.occurrences));
				if (m_axis_tdata[14:8] !== want.element_count)
					report_mismatch("element_count", int'(m_axis_tdata[14:8]),
						int'(want.element_count));
				if (m_axis_tdata[15] !== want.is_empty)
					report_mismatch("is_empty", int'(m_axis_tdata[15]), int'(want.is_empty));
				if (m_axis_tdata[16] !== want.overflow)
					report_mismatch("overflow", int'(m_axis_tdata[16]), int'(want.overflow));
			end
			result_count++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("sorted_multiset_table verification failed");
			$finish;
		end
	end

	task automatic push_op(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value,
			logic [REPEAT_W-1:0] reps);
		op_item_t op;
		op.mode = mode;
		op.value = value;
		op.reps = reps;
		pending_ops.push_back(op);
		queued_count++;
	endtask

	// wait until every queued operation is taken and answered
	task automatic wait_drained();
		while (accepted_count != queued_count || expected_res.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_order(logic desc);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= desc;
		@(posedge clk);
		cfg_we <= 1'b0;
		order_desc = desc;
	endtask

	// remove every stored entry; only called with the table idle
	task automatic clear_table();
		int n;
		n = table_size;
		for (int i = 0; i < n; i++)
			push_op(MODE_REMOVE, shadow_vals[i], 7'd0);
	endtask

	task automatic refresh_pool();
		pool_vals[0] = VAL_MIN;
		pool_vals[1] = VAL_MAX;
		pool_vals[2] = 0;
		pool_vals[3] = -1;
		pool_vals[4] = $signed($urandom_range(0, 20)) - 10;
		pool_vals[5] = $signed($urandom_range(0, 20)) - 10;
		pool_vals[6] = $urandom;
		pool_vals[7] = $urandom;
	endtask

	// random operations, mostly on pool values, with a few stray values
	task automatic run_random(int n_items, int add_pct);
		logic [MODE_W-1:0]         mode;
		logic signed [VALUE_W-1:0] value;
		logic [REPEAT_W-1:0]       reps;
		int                        pick;
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < add_pct)
				mode = MODE_ADD;
			else begin
				pick = $urandom_range(0, 9);
				mode = (pick < 4) ? MODE_REMOVE : (pick < 7) ? MODE_SEARCH : MODE_COUNT;
			end
			if ($urandom_range(0, 99) < 85)
				value = pool_vals[3'($urandom_range(0, 7))];
			else
				value = $urandom;
			pick = $urandom_range(0, 99);
			if (mode != MODE_ADD)
				reps = REPEAT_W'($urandom_range(0, 127));
			else if (pick < 8)
				reps = 7'd0;
			else if (pick < 80)
				reps = REPEAT_W'($urandom_range(1, 3));
			else if (pick < 95)
				reps = REPEAT_W'($urandom_range(4, 16));
			else
				reps = REPEAT_W'($urandom_range(17, 127));
			push_op(mode, value, reps);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, zero copies, extremes, refused adds, full table
		push_op(MODE_SEARCH, 7, 7'd0);
		push_op(MODE_COUNT, 7, 7'd0);
		push_op(MODE_REMOVE, 7, 7'd0);
		push_op(MODE_ADD, 7, 7'd0);
		push_op(MODE_ADD, VAL_MIN, 7'd1);
		push_op(MODE_ADD, VAL_MAX, 7'd1);
		push_op(MODE_ADD, 0, 7'd3);
		push_op(MODE_ADD, -1, 7'd2);
		push_op(MODE_COUNT, 0, 7'd0);
		push_op(MODE_REMOVE, VAL_MIN, 7'd0);
		push_op(MODE_REMOVE, 12345, 7'd0);
		push_op(MODE_ADD, 9, 7'd127);
		push_op(MODE_ADD, 5, 7'd58);
		push_op(MODE_ADD, 1, 7'd1);
		push_op(MODE_COUNT, 5, 7'd0);
		push_op(MODE_SEARCH, VAL_MAX, 7'd0);
		wait_drained();

		// whole table holding one value
		clear_table();
		wait_drained();
		push_op(MODE_ADD, -7, 7'd64);
		push_op(MODE_COUNT, -7, 7'd0);
		push_op(MODE_SEARCH, -7, 7'd0);
		wait_drained();
		clear_table();
		wait_drained();

		// descending order from empty
		write_order(1'b1);
		push_op(MODE_ADD, 3, 7'd10);
		push_op(MODE_ADD, VAL_MIN, 7'd5);
		push_op(MODE_ADD, VAL_MAX, 7'd5);
		push_op(MODE_COUNT, 3, 7'd0);
		push_op(MODE_REMOVE, VAL_MAX, 7'd0);
		push_op(MODE_SEARCH, VAL_MIN, 7'd0);
		wait_drained();

		refresh_pool();
		run_random(220, 35);
		wait_drained();

		// order flipped with the table filled; sender pause, then long hold-off
		write_order(1'b0);
		refresh_pool();
		run_random(110, 40);
		wait_drained();
		run_random(110, 30);
		stall_ticket <= stall_ticket + 1;
		wait_drained();

		write_order(1'b1);
		refresh_pool();
		run_random(220, 25);
		wait_drained();

		write_order(1'b0);
		refresh_pool();
		run_random(220, 45);
		wait_drained();

		write_order(1'b1);
		run_random(220, 35);
		wait_drained();

		// last stretch without idling on either side
		calm <= 1'b1;
		write_order(1'b0);
		refresh_pool();
		run_random(200, 35);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d operations in both orders over %0d cycles", accepted_count,
			cycle_count);
		$display("%0d adds refused for lack of room, %0d removes or searches hit, %0d mismatches",
			refused_adds, hit_count, mismatch_count);
		if (mismatch_count == 0)
			$display("sorted_multiset_table verification clean");
		else
			$display("sorted_multiset_table verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/smt_pkg.sv
rtl/core/smt_ram.sv
rtl/core/smt_seq.sv
rtl/core/sorted_multiset_table.sv
bench/sorted_multiset_table_test.sv
